>>> sv/sebas_pkg.sv
`default_nettype none

package sebas_pkg;

  localparam int AddrBits = 7;
  localparam logic [6:0] AddrMask = 7'((1 << AddrBits) - 1);

  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpXfer  = 2'd2;

  localparam logic [1:0] ActXfer    = 2'd0;
  localparam logic [1:0] ActRelease = 2'd1;
  localparam logic [1:0] ActDone    = 2'd2;

  localparam logic [7:0] CmdRead  = 8'h03;
  localparam logic [7:0] CmdWrite = 8'h02;
  localparam logic [7:0] CmdWren  = 8'h06;
  localparam logic [7:0] CmdRdsr  = 8'h05;

  localparam int QDepth   = 4;
  localparam int QPtrBits = $clog2(QDepth);
  localparam int QCntBits = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] mem_addr;
    logic [7:0] write_value;
    logic [7:0] rx_byte;
  } sebas_in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic [7:0] read_value;
    logic       last;
  } sebas_out_t;

  typedef struct packed {
    logic [1:0] count;
    sebas_out_t first;
    sebas_out_t second;
  } sebas_push_t;

endpackage

`default_nettype wire

>>> sv/sebas_step.sv
`default_nettype none

module sebas_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sebas_pkg::sebas_in_t  in_item,
  input  logic                  room,
  output sebas_pkg::sebas_push_t push
);
  import sebas_pkg::*;

  typedef enum logic [3:0] {
    PhIdle,
    PhRdCmd,
    PhRdAddr,
    PhRdDummy,
    PhWrEn,
    PhWrCmd,
    PhWrAddr,
    PhWrData,
    PhPollCmd,
    PhPollDummy
  } phase_t;

  phase_t     phase, phase_next;
  logic [6:0] held_address, held_address_next;
  logic [7:0] held_data, held_data_next;
  sebas_in_t  in_reg;
  logic       in_reg_valid;
  logic       accept;
  logic       go;
  logic [7:0] addr_byte;

  function automatic sebas_out_t mk(logic [1:0] act, logic [7:0] tx, logic [7:0] rv,
                                    logic lst);
    sebas_out_t r;
    r.action     = act;
    r.tx_byte    = tx;
    r.read_value = rv;
    r.last       = lst;
    return r;
  endfunction

  assign go       = in_reg_valid && room;
  assign in_stall = rst || (in_reg_valid && !room);
  assign accept   = in_valid && !in_stall;
  assign addr_byte = {1'b0, held_address};

  always_comb begin
    phase_next        = phase;
    held_address_next = held_address;
    held_data_next    = held_data;
    push              = '0;
    if (go) begin
      if (phase == PhIdle) begin
        case (in_reg.op)
          OpRead: begin
            held_address_next = in_reg.mem_addr & AddrMask;
            phase_next        = PhRdCmd;
            push.count        = 2'd1;
            push.first        = mk(ActXfer, CmdRead, 8'd0, 1'b1);
          end
          OpWrite: begin
            held_address_next = in_reg.mem_addr & AddrMask;
            held_data_next    = in_reg.write_value;
            phase_next        = PhWrEn;
            push.count        = 2'd1;
            push.first        = mk(ActXfer, CmdWren, 8'd0, 1'b1);
          end
          default: ;
        endcase
      end else if (in_reg.op == OpXfer) begin
        unique case (phase)
          PhRdCmd: begin
            phase_next = PhRdAddr;
            push.count = 2'd1;
            push.first = mk(ActXfer, addr_byte, 8'd0, 1'b1);
          end
          PhRdAddr: begin
            phase_next = PhRdDummy;
            push.count = 2'd1;
            push.first = mk(ActXfer, 8'd0, 8'd0, 1'b1);
          end
          PhRdDummy: begin
            phase_next  = PhIdle;
            push.count  = 2'd2;
            push.first  = mk(ActRelease, 8'd0, 8'd0, 1'b0);
            push.second = mk(ActDone, 8'd0, in_reg.rx_byte, 1'b1);
          end
          PhWrEn: begin
            phase_next  = PhWrCmd;
            push.count  = 2'd2;
            push.first  = mk(ActRelease, 8'd0, 8'd0, 1'b0);
            push.second = mk(ActXfer, CmdWrite, 8'd0, 1'b1);
          end
          PhWrCmd: begin
            phase_next = PhWrAddr;
            push.count = 2'd1;
            push.first = mk(ActXfer, addr_byte, 8'd0, 1'b1);
          end
          PhWrAddr: begin
            phase_next = PhWrData;
            push.count = 2'd1;
            push.first = mk(ActXfer, held_data, 8'd0, 1'b1);
          end
          PhWrData: begin
            phase_next  = PhPollCmd;
            push.count  = 2'd2;
            push.first  = mk(ActRelease, 8'd0, 8'd0, 1'b0);
            push.second = mk(ActXfer, CmdRdsr, 8'd0, 1'b1);
          end
          PhPollCmd: begin
            phase_next = PhPollDummy;
            push.count = 2'd1;
            push.first = mk(ActXfer, 8'd0, 8'd0, 1'b1);
          end
          PhPollDummy: begin
            push.count = 2'd2;
            push.first = mk(ActRelease, 8'd0, 8'd0, 1'b0);
            if (!in_reg.rx_byte[0]) begin
              phase_next  = PhIdle;
              push.second = mk(ActDone, 8'd0, 8'd0, 1'b1);
            end else begin
              phase_next  = PhPollCmd;
              push.second = mk(ActXfer, CmdRdsr, 8'd0, 1'b1);
            end
          end
          default: begin
            phase_next = PhIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhIdle;
      held_address <= '0;
      held_data    <= '0;
      in_reg_valid <= 1'b0;
    end else begin
      phase        <= phase_next;
      held_address <= held_address_next;
      held_data    <= held_data_next;
      if (accept) begin
        in_reg_valid <= 1'b1;
        in_reg       <= in_item;
      end else if (go) begin
        in_reg_valid <= 1'b0;
      end
    end
  end

  a_push_needs_item: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (in_reg_valid && room))
    else $error("results pushed without a pending item");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (!push.first.last && push.second.last))
    else $error("last flag misplaced in a result pair");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd1) |-> push.first.last)
    else $error("single result lacks last flag");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2 && push.second.action == ActDone) |=> (phase == PhIdle))
    else $error("finished request did not return to idle");

endmodule

`default_nettype wire

>>> sv/sebas_outq.sv
`default_nettype none

module sebas_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  sebas_pkg::sebas_push_t push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sebas_pkg::sebas_out_t  out_item
);
  import sebas_pkg::*;

  sebas_out_t          q [QDepth];
  logic [QPtrBits-1:0] wr_ptr, rd_ptr;
  logic [QPtrBits-1:0] wr_ptr_plus;
  logic [QCntBits-1:0] count, count_next;
  logic                pop;

  assign out_valid   = (count != '0);
  assign out_item    = q[rd_ptr];
  assign pop         = out_valid && !out_stall;
  assign room        = (count <= QCntBits'(QDepth - 2));
  assign wr_ptr_plus = wr_ptr + QPtrBits'(1);
  assign count_next  = count + QCntBits'(push.count) - QCntBits'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      wr_ptr <= wr_ptr + QPtrBits'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      q[wr_ptr_plus] <= push.second;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntBits'(QDepth))
    else $error("result queue overflow");

  a_pair_fits: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("push into a queue without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count_next)))
    else $error("queue count out of step");

endmodule

`default_nettype wire

>>> sv/spi_eeprom_byte_access_sequencer.sv
`default_nettype none

// Channel  Direction  Payload      Handshake
// in       input      sebas_in_t   in_valid / in_stall
// out      output     sebas_out_t  out_valid / out_stall
//
// An accepted item is registered and decoded when the queue has room; its
// results (none, one or two) go into a four-entry result queue.
// One item is taken per cycle while the queue has room for two results; the
// queue drains one result per unstalled cycle; two-result items set the pace.
// Reset clears the phase, the held address and data, and the queue.
// A stalled output only fills the queue; a registered item waits, and the input
// stalls, while fewer than two slots remain free.

module spi_eeprom_byte_access_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sebas_pkg::sebas_in_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sebas_pkg::sebas_out_t out_item
);
  import sebas_pkg::*;

  sebas_push_t push;
  logic        room;

  sebas_step u_step (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .room     (room),
    .push     (push)
  );

  sebas_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> sim/spi_eeprom_byte_access_sequencer_checker.sv
module spi_eeprom_byte_access_sequencer_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  sebas_pkg::sebas_in_t  in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  sebas_pkg::sebas_out_t out_item,
  output int                    mismatches,
  output int                    outstanding,
  output int                    items_taken,
  output int                    ignored_items,
  output int                    reads_done,
  output int                    writes_done,
  output int                    status_retries
);
  timeunit 1ns;
  timeprecision 1ps;
  import sebas_pkg::*;

  typedef enum logic [3:0] {
    SeqIdle, SeqRdCmd, SeqRdAddr, SeqRdDummy, SeqWrEn, SeqWrCmd, SeqWrAddr, SeqWrData,
    SeqPollCmd, SeqPollDummy
  } seq_phase_t;

  seq_phase_t phase;
  logic [6:0] held_addr;
  logic [7:0] held_data;
  sebas_out_t pending_replies[$];

  task automatic queue_reply(input logic [1:0] act, input logic [7:0] tx,
                             input logic [7:0] rv, input logic last);
    sebas_out_t r;
    r.action = act;
    r.tx_byte = tx;
    r.read_value = rv;
    r.last = last;
    pending_replies.push_back(r);
  endtask

  task automatic predict_replies(input sebas_in_t it);
    if (phase == SeqIdle) begin
      if (it.op == OpRead) begin
        held_addr = it.mem_addr & AddrMask;
        phase = SeqRdCmd;
        queue_reply(ActXfer, CmdRead, 8'h00, 1'b1);
      end else if (it.op == OpWrite) begin
        held_addr = it.mem_addr & AddrMask;
        held_data = it.write_value;
        phase = SeqWrEn;
        queue_reply(ActXfer, CmdWren, 8'h00, 1'b1);
      end else begin
        ignored_items++;
      end
    end else if (it.op != OpXfer) begin
      ignored_items++;
    end else begin
      case (phase)
        SeqRdCmd: begin
          phase = SeqRdAddr;
          queue_reply(ActXfer, {1'b0, held_addr}, 8'h00, 1'b1);
        end
        SeqRdAddr: begin
          phase = SeqRdDummy;
          queue_reply(ActXfer, 8'h00, 8'h00, 1'b1);
        end
        SeqRdDummy: begin
          phase = SeqIdle;
          reads_done++;
          queue_reply(ActRelease, 8'h00, 8'h00, 1'b0);
          queue_reply(ActDone, 8'h00, it.rx_byte, 1'b1);
        end
        SeqWrEn: begin
          phase = SeqWrCmd;
          queue_reply(ActRelease, 8'h00, 8'h00, 1'b0);
          queue_reply(ActXfer, CmdWrite, 8'h00, 1'b1);
        end
        SeqWrCmd: begin
          phase = SeqWrAddr;
          queue_reply(ActXfer, {1'b0, held_addr}, 8'h00, 1'b1);
        end
        SeqWrAddr: begin
          phase = SeqWrData;
          queue_reply(ActXfer, held_data, 8'h00, 1'b1);
        end
        SeqWrData: begin
          phase = SeqPollCmd;
          queue_reply(ActRelease, 8'h00, 8'h00, 1'b0);
          queue_reply(ActXfer, CmdRdsr, 8'h00, 1'b1);
        end
        SeqPollCmd: begin
          phase = SeqPollDummy;
          queue_reply(ActXfer, 8'h00, 8'h00, 1'b1);
        end
        SeqPollDummy: begin
          queue_reply(ActRelease, 8'h00, 8'h00, 1'b0);
          if (it.rx_byte[0] == 1'b0) begin
            phase = SeqIdle;
            writes_done++;
            queue_reply(ActDone, 8'h00, 8'h00, 1'b1);
          end else begin
            phase = SeqPollCmd;
            status_retries++;
            queue_reply(ActXfer, CmdRdsr, 8'h00, 1'b1);
          end
        end
        default: begin
          phase = SeqIdle;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    sebas_out_t want;
    if (rst) begin
      phase = SeqIdle;
      held_addr = '0;
      held_data = '0;
      pending_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reply: action=%0d tx=%h read=%h last=%b", $time,
                   out_item.action, out_item.tx_byte, out_item.read_value, out_item.last);
        end else begin
          want = pending_replies.pop_front();
          if (out_item.action !== want.action || out_item.tx_byte !== want.tx_byte ||
              out_item.read_value !== want.read_value || out_item.last !== want.last) begin
            mismatches++;
            $display("%0t: reply mismatch: expected action=%0d tx=%h read=%h last=%b",
                     $time, want.action, want.tx_byte, want.read_value, want.last);
            $display("%0t:                   actual action=%0d tx=%h read=%h last=%b",
                     $time, out_item.action, out_item.tx_byte, out_item.read_value,
                     out_item.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        items_taken++;
        predict_replies(in_item);
      end
    end
    outstanding = pending_replies.size();
  end

endmodule

>>> sim/tb_spi_eeprom_byte_access_sequencer.sv
module tb_spi_eeprom_byte_access_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import sebas_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  sebas_in_t  in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  sebas_out_t out_item;

  int mismatches, outstanding, items_taken, ignored_items;
  int reads_done, writes_done, status_retries;
  int src_idle_pct = 32;
  int sink_stall_pct = 86;
  int real_items = 0;
  int goal;

  spi_eeprom_byte_access_sequencer i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  spi_eeprom_byte_access_sequencer_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .items_taken   (items_taken),
    .ignored_items (ignored_items),
    .reads_done    (reads_done),
    .writes_done   (writes_done),
    .status_retries(status_retries)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  function automatic sebas_in_t stray(input logic [1:0] op);
    sebas_in_t it;
    it = $bits(sebas_in_t)'($urandom);
    it.op = op;
    return it;
  endfunction

  function automatic sebas_in_t busy_noise();
    case ($urandom_range(2))
      0: return stray(OpRead);
      1: return stray(OpWrite);
      default: return stray(OpUnused);
    endcase
  endfunction

  task automatic offer(input sebas_in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      in_item <= $bits(sebas_in_t)'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic exchange_done(input logic [7:0] rx, input int noise_pct);
    sebas_in_t it;
    if ($urandom_range(99) < noise_pct) offer(busy_noise());
    it = stray(OpXfer);
    it.rx_byte = rx;
    offer(it);
    real_items++;
  endtask

  task automatic do_read(input logic [6:0] addr, input logic [7:0] data, input int noise_pct);
    sebas_in_t it;
    it = stray(OpRead);
    it.mem_addr = addr;
    offer(it);
    real_items++;
    exchange_done(8'($urandom), noise_pct);
    exchange_done(8'($urandom), noise_pct);
    exchange_done(data, noise_pct);
  endtask

  task automatic do_write(input logic [6:0] addr, input logic [7:0] data, input int busy_polls,
                          input int noise_pct);
    sebas_in_t it;
    it = stray(OpWrite);
    it.mem_addr = addr;
    it.write_value = data;
    offer(it);
    real_items++;
    repeat (4) exchange_done(8'($urandom), noise_pct);
    repeat (busy_polls) begin
      exchange_done(8'($urandom), noise_pct);
      exchange_done(8'($urandom) | 8'h01, noise_pct);
    end
    exchange_done(8'($urandom), noise_pct);
    exchange_done(8'($urandom) & 8'hFE, noise_pct);
  endtask

  task automatic random_traffic(input int target);
    while (real_items < target) begin
      if ($urandom_range(99) < 10) offer(stray($urandom_range(1) ? OpXfer : OpUnused));
      if ($urandom_range(1)) begin
        do_read(7'($urandom), 8'($urandom), 10);
      end else begin
        do_write(7'($urandom), 8'($urandom),
                 ($urandom_range(99) < 60) ? 0 : $urandom_range(3, 1), 10);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer(stray(OpXfer));
    offer(stray(OpUnused));
    do_read(7'h7F, 8'hFF, 100);
    do_write(7'h7F, 8'h00, 2, 0);
    do_write(7'h00, 8'hFF, 0, 0);

    goal = real_items + 545;
    random_traffic(goal);
    src_idle_pct = 86;
    sink_stall_pct = 32;
    goal = real_items + 545;
    random_traffic(goal);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    goal = real_items + 545;
    random_traffic(goal);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("Ran %0d items (%0d ignored as noise) under three idle mixes:", items_taken,
             ignored_items);
    $display("%0d reads and %0d writes completed, %0d busy status polls.", reads_done,
             writes_done, status_retries);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
